[rtl/dtw_pkg.sv]
// Shared types and constants of the DER TLV stream walker.
// Used by the front end, the result queue, the back end and the checker.
package dtw_pkg;

  localparam int MAX_ARCS      = 8;
  localparam int MAX_LEN_BYTES = 4;
  localparam int MAX_RES       = 3;
  localparam int FIFO_DEPTH    = 4;

  localparam int ARC_CNT_W  = $clog2(MAX_ARCS + 1);
  localparam int LEN_LEFT_W = $clog2(MAX_LEN_BYTES + 1);
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W  = $clog2(MAX_RES);
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [4:0] TAG_INTEGER  = 5'd2;
  localparam logic [4:0] TAG_OID      = 5'd6;
  localparam logic [4:0] TAG_SEQUENCE = 5'd16;
  localparam logic [4:0] TAG_SET      = 5'd17;

  localparam logic [1:0] ERR_TRUNC    = 2'd0;
  localparam logic [1:0] ERR_LEN_FORM = 2'd1;
  localparam logic [1:0] ERR_LONG_ARC = 2'd2;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_ARC    = 3'd1,
    KIND_INT    = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LENX = 3'd2,
    PH_SKIP = 3'd3,
    PH_INT  = 3'd4,
    PH_OID  = 3'd5,
    PH_HALT = 3'd6
  } phase_t;

  // One result in compact form: val carries the arc or the integer value.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [31:0] len;
    logic [31:0] val;
    logic [1:0]  err;
  } res_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [RES_CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0]     res;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/dtw_front.sv]
// Front end: accepts DER bytes and runs the TLV decode state machine.
// Builds the group of results each byte causes. Depends on dtw_pkg.
module dtw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  dtw_pkg::fifo_stat_t q_stat,
  output logic                q_push,
  output dtw_pkg::grp_t       q_grp
);

  dtw_pkg::phase_t                   phase_r, phase_nxt;
  logic [7:0]                        tag_r, tag_nxt;
  logic [31:0]                       len_acc_r, len_acc_nxt;
  logic [dtw_pkg::LEN_LEFT_W-1:0]    len_left_r, len_left_nxt;
  logic [31:0]                       content_r, content_nxt;
  logic [27:0]                       arc_acc_r, arc_acc_nxt;
  logic [1:0]                        arc_dig_r, arc_dig_nxt;
  logic [dtw_pkg::ARC_CNT_W-1:0]     arc_cnt_r, arc_cnt_nxt;
  logic                              first_r, first_nxt;
  logic [31:0]                       int_r, int_nxt;
  logic [31:0]                       outer_r, outer_nxt;

  logic accept;

  function automatic dtw_pkg::grp_t add_res(dtw_pkg::grp_t g, dtw_pkg::kind_t k,
                                            logic [7:0] tag, logic [31:0] len,
                                            logic [31:0] val, logic [1:0] err);
    dtw_pkg::res_t r;
    r.kind = k;
    r.tag  = tag;
    r.len  = len;
    r.val  = val;
    r.err  = err;
    if (g.cnt != dtw_pkg::RES_CNT_W'(dtw_pkg::MAX_RES)) begin
      g.res[g.cnt[dtw_pkg::RES_IDX_W-1:0]] = r;
      g.cnt = g.cnt + 1'b1;
    end
    return g;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (q_grp.cnt != '0);

  always_comb begin
    logic [31:0] outer_dec;
    logic [31:0] hlen;
    logic [4:0]  tnum;
    logic [27:0] v;
    logic        hdr_done;
    logic        failed;
    dtw_pkg::grp_t g;

    phase_nxt    = phase_r;
    tag_nxt      = tag_r;
    len_acc_nxt  = len_acc_r;
    len_left_nxt = len_left_r;
    content_nxt  = content_r;
    arc_acc_nxt  = arc_acc_r;
    arc_dig_nxt  = arc_dig_r;
    arc_cnt_nxt  = arc_cnt_r;
    first_nxt    = first_r;
    int_nxt      = int_r;
    hdr_done     = 1'b0;
    failed       = 1'b0;
    g            = '0;
    v            = {arc_acc_r[20:0], in_data_byte[6:0]};
    outer_dec    = (outer_r != '0) ? outer_r - 32'd1 : outer_r;
    outer_nxt    = outer_dec;

    unique case (phase_r)
      dtw_pkg::PH_TAG: begin
        tag_nxt      = in_data_byte;
        len_acc_nxt  = '0;
        len_left_nxt = '0;
        phase_nxt    = dtw_pkg::PH_LEN1;
      end
      dtw_pkg::PH_LEN1: begin
        if (in_data_byte[7]) begin
          if (in_data_byte[6:0] == 7'd0 ||
              in_data_byte[6:0] > 7'(dtw_pkg::MAX_LEN_BYTES)) begin
            g         = add_res(g, dtw_pkg::KIND_ERROR, '0, '0, '0, dtw_pkg::ERR_LEN_FORM);
            phase_nxt = dtw_pkg::PH_HALT;
          end else begin
            len_acc_nxt  = '0;
            len_left_nxt = in_data_byte[dtw_pkg::LEN_LEFT_W-1:0];
            phase_nxt    = dtw_pkg::PH_LENX;
          end
        end else begin
          len_acc_nxt = {25'd0, in_data_byte[6:0]};
          hdr_done    = 1'b1;
        end
      end
      dtw_pkg::PH_LENX: begin
        len_acc_nxt  = {len_acc_r[23:0], in_data_byte};
        len_left_nxt = len_left_r - 1'b1;
        if (len_left_r == dtw_pkg::LEN_LEFT_W'(1)) begin
          hdr_done = 1'b1;
        end
      end
      dtw_pkg::PH_SKIP: begin
        content_nxt = content_r - 32'd1;
        if (content_r == 32'd1) begin
          phase_nxt = dtw_pkg::PH_TAG;
        end
      end
      dtw_pkg::PH_INT: begin
        int_nxt     = {int_r[23:0], in_data_byte};
        content_nxt = content_r - 32'd1;
        if (content_r == 32'd1) begin
          g         = add_res(g, dtw_pkg::KIND_INT, '0, '0, int_nxt, '0);
          phase_nxt = dtw_pkg::PH_TAG;
        end
      end
      dtw_pkg::PH_OID: begin
        if (in_data_byte[7]) begin
          if (arc_dig_r == 2'd3) begin
            g         = add_res(g, dtw_pkg::KIND_ERROR, '0, '0, '0, dtw_pkg::ERR_LONG_ARC);
            phase_nxt = dtw_pkg::PH_HALT;
            failed    = 1'b1;
          end else begin
            arc_acc_nxt = v;
            arc_dig_nxt = arc_dig_r + 1'b1;
          end
        end else begin
          arc_acc_nxt = '0;
          arc_dig_nxt = '0;
          if (first_r) begin
            // First subidentifier carries two arcs: 40 * X + Y.
            first_nxt = 1'b0;
            g = add_res(g, dtw_pkg::KIND_ARC, '0, '0,
                        (v < 28'd40) ? 32'd0 : ((v < 28'd80) ? 32'd1 : 32'd2), '0);
            g = add_res(g, dtw_pkg::KIND_ARC, '0, '0,
                        {4'd0, (v < 28'd40) ? v :
                               ((v < 28'd80) ? v - 28'd40 : v - 28'd80)}, '0);
            arc_cnt_nxt = arc_cnt_r + dtw_pkg::ARC_CNT_W'(2);
          end else if (arc_cnt_r < dtw_pkg::ARC_CNT_W'(dtw_pkg::MAX_ARCS)) begin
            g           = add_res(g, dtw_pkg::KIND_ARC, '0, '0, {4'd0, v}, '0);
            arc_cnt_nxt = arc_cnt_r + 1'b1;
          end
        end
        if (!failed) begin
          content_nxt = content_r - 32'd1;
          if (content_r == 32'd1) begin
            phase_nxt = dtw_pkg::PH_TAG;
          end
        end
      end
      default: begin
        phase_nxt = dtw_pkg::PH_HALT;
      end
    endcase

    hlen = len_acc_nxt;
    tnum = tag_r[4:0];
    if (hdr_done) begin
      g           = add_res(g, dtw_pkg::KIND_HEADER, tag_r, hlen, '0, '0);
      int_nxt     = '0;
      arc_acc_nxt = '0;
      arc_dig_nxt = '0;
      arc_cnt_nxt = '0;
      first_nxt   = 1'b1;
      content_nxt = hlen;
      if (tnum == dtw_pkg::TAG_SEQUENCE || tnum == dtw_pkg::TAG_SET) begin
        // Walk into the contents; track the furthest open end.
        if (hlen > outer_dec) begin
          outer_nxt = hlen;
        end
        phase_nxt = dtw_pkg::PH_TAG;
      end else if (hlen == '0) begin
        if (tnum == dtw_pkg::TAG_INTEGER) begin
          g = add_res(g, dtw_pkg::KIND_INT, '0, '0, '0, '0);
        end
        phase_nxt = dtw_pkg::PH_TAG;
      end else if (tnum == dtw_pkg::TAG_INTEGER && hlen <= 32'd4) begin
        phase_nxt = dtw_pkg::PH_INT;
      end else if (tnum == dtw_pkg::TAG_OID) begin
        phase_nxt = dtw_pkg::PH_OID;
      end else begin
        phase_nxt = dtw_pkg::PH_SKIP;
      end
    end

    if (in_last_byte) begin
      if (phase_nxt != dtw_pkg::PH_HALT) begin
        if (phase_nxt != dtw_pkg::PH_TAG || outer_nxt != '0) begin
          g = add_res(g, dtw_pkg::KIND_ERROR, '0, '0, '0, dtw_pkg::ERR_TRUNC);
        end else begin
          g = add_res(g, dtw_pkg::KIND_END, '0, '0, '0, '0);
        end
      end
      phase_nxt    = dtw_pkg::PH_TAG;
      tag_nxt      = '0;
      len_acc_nxt  = '0;
      len_left_nxt = '0;
      content_nxt  = '0;
      arc_acc_nxt  = '0;
      arc_dig_nxt  = '0;
      arc_cnt_nxt  = '0;
      first_nxt    = 1'b1;
      int_nxt      = '0;
      outer_nxt    = '0;
    end

    q_grp = g;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dtw_pkg::PH_TAG;
      tag_r      <= '0;
      len_acc_r  <= '0;
      len_left_r <= '0;
      content_r  <= '0;
      arc_acc_r  <= '0;
      arc_dig_r  <= '0;
      arc_cnt_r  <= '0;
      first_r    <= 1'b1;
      int_r      <= '0;
      outer_r    <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      tag_r      <= tag_nxt;
      len_acc_r  <= len_acc_nxt;
      len_left_r <= len_left_nxt;
      content_r  <= content_nxt;
      arc_acc_r  <= arc_acc_nxt;
      arc_dig_r  <= arc_dig_nxt;
      arc_cnt_r  <= arc_cnt_nxt;
      first_r    <= first_nxt;
      int_r      <= int_nxt;
      outer_r    <= outer_nxt;
    end
  end

endmodule

[rtl/dtw_fifo.sv]
// Result-group queue between the front end and the back end.
// Holds FIFO_DEPTH groups of results. Depends on dtw_pkg.
module dtw_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dtw_pkg::grp_t       push_grp,
  input  logic                pop,
  output dtw_pkg::grp_t       head_grp,
  output dtw_pkg::fifo_stat_t stat
);

  dtw_pkg::grp_t                  mem_r [dtw_pkg::FIFO_DEPTH];
  logic [dtw_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [dtw_pkg::FIFO_CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == dtw_pkg::FIFO_CNT_W'(dtw_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_grp   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/dtw_back.sv]
// Back end: takes result groups from the queue and drives them out one
// result per transaction, marking the last of each group. Depends on dtw_pkg.
module dtw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dtw_pkg::fifo_stat_t q_stat,
  input  dtw_pkg::grp_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic [1:0]          out_tag_class,
  output logic                out_constructed,
  output logic [4:0]          out_tag_number,
  output logic [31:0]         out_value_length,
  output logic [27:0]         out_arc_value,
  output logic [31:0]         out_int_value,
  output logic [1:0]          out_error_code,
  output logic                out_last
);

  dtw_pkg::grp_t                 grp_r;
  logic [dtw_pkg::RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                          busy_r, busy_nxt;
  dtw_pkg::res_t                 cur;
  logic [dtw_pkg::RES_CNT_W-1:0] cnt_m1;
  logic                          at_end;
  logic                          is_hdr;

  assign cur    = grp_r.res[idx_r];
  assign cnt_m1 = grp_r.cnt - 1'b1;
  assign at_end = (dtw_pkg::RES_CNT_W'(idx_r) == cnt_m1);
  assign is_hdr = (cur.kind == dtw_pkg::KIND_HEADER);

  // Load the next group when idle or when the final result leaves.
  assign q_pop = !q_stat.empty && (!busy_r || (out_ready && at_end));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && out_ready) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_r <= q_head;
    end
  end

  assign out_valid        = busy_r;
  assign out_kind         = cur.kind;
  assign out_tag_class    = is_hdr ? cur.tag[7:6] : 2'd0;
  assign out_constructed  = is_hdr ? cur.tag[5] : 1'b0;
  assign out_tag_number   = is_hdr ? cur.tag[4:0] : 5'd0;
  assign out_value_length = is_hdr ? cur.len : 32'd0;
  assign out_arc_value    = (cur.kind == dtw_pkg::KIND_ARC) ? cur.val[27:0] : 28'd0;
  assign out_int_value    = (cur.kind == dtw_pkg::KIND_INT) ? cur.val : 32'd0;
  assign out_error_code   = (cur.kind == dtw_pkg::KIND_ERROR) ? cur.err : 2'd0;
  assign out_last         = at_end;

endmodule

[rtl/der_tlv_stream_walker.sv]
// Top level of the DER TLV stream walker: front end, result queue, back end.
// Depends on dtw_pkg, dtw_front, dtw_fifo and dtw_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one DER byte per transaction, with
//   in_last_byte set on the final byte of a buffer. The next transaction
//   after a final byte starts a new buffer from a clean state.
//   Output channel (out_valid/out_ready): one result per transaction:
//   a TLV header, an OID arc, an INTEGER value, an error, or a clean end.
//   out_last marks the last result caused by one input byte.
// Output path: a byte's results are written to the queue, then loaded into
//   the back end, and only then presented on the output channel.
// Throughput: one byte per cycle while each byte yields at most one result and
//   out_ready stays high; a byte that yields several results (up to three)
//   holds the output port until all of them have left. The decode state machine
//   takes a byte every cycle until the queue fills; the output port, one result per cycle, sets the sustained rate.
// Stall: while out_ready is low the current result holds; the front end keeps
//   taking bytes until the four-group queue fills, then drops in_ready.
// Reset: synchronous active-low rst_n empties the queue, drops out_valid and
//   returns the decoder to expect a tag byte. No clearing pass is needed.
module der_tlv_stream_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_tag_class,
  output logic        out_constructed,
  output logic [4:0]  out_tag_number,
  output logic [31:0] out_value_length,
  output logic [27:0] out_arc_value,
  output logic [31:0] out_int_value,
  output logic [1:0]  out_error_code,
  output logic        out_last
);

  // Queue handshake and status between front and back.
  dtw_pkg::fifo_stat_t q_stat;
  dtw_pkg::grp_t       q_push_grp;
  dtw_pkg::grp_t       q_head;
  logic                q_push;
  logic                q_pop;

  // Decode bytes; push every group that holds at least one result.
  dtw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_grp        (q_push_grp)
  );

  // Decouple decode from output stalls.
  dtw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_grp (q_push_grp),
    .pop      (q_pop),
    .head_grp (q_head),
    .stat     (q_stat)
  );

  // Serialize each group onto the output channel.
  dtw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tag_class    (out_tag_class),
    .out_constructed  (out_constructed),
    .out_tag_number   (out_tag_number),
    .out_value_length (out_value_length),
    .out_arc_value    (out_arc_value),
    .out_int_value    (out_int_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

[rtl/dtw_checker.sv]
// Port-level checks of the DER TLV stream walker, bound to the top level.
// Depends on dtw_pkg and der_tlv_stream_walker.
module dtw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [1:0]  out_tag_class,
  input logic        out_constructed,
  input logic [4:0]  out_tag_number,
  input logic [31:0] out_value_length,
  input logic [27:0] out_arc_value,
  input logic [31:0] out_int_value,
  input logic        out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last) &&
      $stable(out_value_length) && $stable(out_arc_value) && $stable(out_int_value))
    else $error("stalled result changed");

  // Reset drops the output channel.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // A clean end always closes its byte's results.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == 3'(dtw_pkg::KIND_END) |-> out_last)
    else $error("clean end not marked last");

  // Header fields appear only on headers.
  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != 3'(dtw_pkg::KIND_HEADER) |->
      out_tag_number == 5'd0 && out_tag_class == 2'd0 && !out_constructed &&
      out_value_length == 32'd0)
    else $error("header fields on non-header result");

endmodule

bind der_tlv_stream_walker dtw_checker u_dtw_checker (.*);

[test/der_tlv_walk_checker.sv]
// Scoreboard for the DER TLV stream walker: predicts the results of every
// accepted byte and compares them with the output channel, field by field.
// Depends on dtw_pkg for the result kinds, phases, tag numbers and error codes.
module der_tlv_walk_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [1:0]  out_tag_class,
  input  logic        out_constructed,
  input  logic [4:0]  out_tag_number,
  input  logic [31:0] out_value_length,
  input  logic [27:0] out_arc_value,
  input  logic [31:0] out_int_value,
  input  logic [1:0]  out_error_code,
  input  logic        out_last,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned INT_MAX_BYTES = 4;

  typedef struct packed {
    dtw_pkg::kind_t kind;
    logic [1:0]     cls;
    logic           cons;
    logic [4:0]     tnum;
    logic [31:0]    vlen;
    logic [27:0]    arc;
    logic [31:0]    ival;
    logic [1:0]     err;
    logic           last;
  } walk_res_t;

  // Decoder state as the walker keeps it.
  dtw_pkg::phase_t ph;
  logic [7:0]  tag_r;
  logic [31:0] len_acc;
  int unsigned len_left;
  logic [31:0] body_left;
  logic [27:0] arc_acc;
  int unsigned arc_dig;
  int unsigned arc_cnt;
  logic        first_sub;
  logic [31:0] int_acc;
  logic        err_hit;
  logic [31:0] seq_left;  // bytes owed to the furthest-reaching open SEQUENCE/SET

  walk_res_t   step_res[dtw_pkg::MAX_RES];
  int unsigned step_n;
  walk_res_t   exp_q[$];
  int unsigned res_idx;

  function automatic void clear_walk();
    ph        = dtw_pkg::PH_TAG;
    tag_r     = '0;
    len_acc   = '0;
    len_left  = 0;
    body_left = '0;
    arc_acc   = '0;
    arc_dig   = 0;
    arc_cnt   = 0;
    first_sub = 1'b1;
    int_acc   = '0;
    err_hit   = 1'b0;
    seq_left  = '0;
  endfunction

  function automatic void add_result(dtw_pkg::kind_t k, logic [31:0] vlen, logic [27:0] arc,
                                     logic [31:0] ival, logic [1:0] err);
    walk_res_t r;
    if (step_n < dtw_pkg::MAX_RES) begin
      r.kind = k;
      r.cls  = (k == dtw_pkg::KIND_HEADER) ? tag_r[7:6] : 2'd0;
      r.cons = (k == dtw_pkg::KIND_HEADER) ? tag_r[5] : 1'b0;
      r.tnum = (k == dtw_pkg::KIND_HEADER) ? tag_r[4:0] : 5'd0;
      r.vlen = vlen;
      r.arc  = arc;
      r.ival = ival;
      r.err  = err;
      r.last = 1'b0;
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void abort_walk(logic [1:0] code);
    add_result(dtw_pkg::KIND_ERROR, '0, '0, '0, code);
    err_hit = 1'b1;
    ph      = dtw_pkg::PH_HALT;
  endfunction

  // Arcs past the cap are consumed but not reported.
  function automatic void add_arc(logic [27:0] v);
    if (arc_cnt < dtw_pkg::MAX_ARCS) begin
      add_result(dtw_pkg::KIND_ARC, '0, v, '0, 2'd0);
      arc_cnt++;
    end
  endfunction

  function automatic void close_header();
    logic [4:0] tn;
    tn = tag_r[4:0];
    add_result(dtw_pkg::KIND_HEADER, len_acc, '0, '0, 2'd0);
    int_acc   = '0;
    arc_acc   = '0;
    arc_dig   = 0;
    arc_cnt   = 0;
    first_sub = 1'b1;
    body_left = len_acc;
    if (tn == dtw_pkg::TAG_SEQUENCE || tn == dtw_pkg::TAG_SET) begin
      if (len_acc > seq_left) seq_left = len_acc;
      ph = dtw_pkg::PH_TAG;
    end else if (len_acc == 0) begin
      if (tn == dtw_pkg::TAG_INTEGER) add_result(dtw_pkg::KIND_INT, '0, '0, '0, 2'd0);
      ph = dtw_pkg::PH_TAG;
    end else if (tn == dtw_pkg::TAG_INTEGER && len_acc <= INT_MAX_BYTES) begin
      ph = dtw_pkg::PH_INT;
    end else if (tn == dtw_pkg::TAG_OID) begin
      ph = dtw_pkg::PH_OID;
    end else begin
      ph = dtw_pkg::PH_SKIP;
    end
  endfunction

  function automatic void take_oid_byte(logic [7:0] b);
    logic [27:0] v;
    if (b[7]) begin
      if (arc_dig >= 3) begin
        abort_walk(dtw_pkg::ERR_LONG_ARC);
      end else begin
        arc_acc = {arc_acc[20:0], b[6:0]};
        arc_dig++;
      end
    end else begin
      v       = {arc_acc[20:0], b[6:0]};
      arc_acc = '0;
      arc_dig = 0;
      if (first_sub) begin
        // first subidentifier carries two arcs
        first_sub = 1'b0;
        if (v < 40) begin
          add_arc(28'd0);
          add_arc(v);
        end else if (v < 80) begin
          add_arc(28'd1);
          add_arc(v - 28'd40);
        end else begin
          add_arc(28'd2);
          add_arc(v - 28'd80);
        end
      end else begin
        add_arc(v);
      end
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    step_n = 0;
    if (seq_left > 0) seq_left--;
    case (ph)
      dtw_pkg::PH_TAG: begin
        tag_r    = b;
        len_acc  = '0;
        len_left = 0;
        ph       = dtw_pkg::PH_LEN1;
      end
      dtw_pkg::PH_LEN1: begin
        if (b[7]) begin
          if (b[6:0] == 7'd0 || int'(b[6:0]) > dtw_pkg::MAX_LEN_BYTES) begin
            abort_walk(dtw_pkg::ERR_LEN_FORM);
          end else begin
            len_acc  = '0;
            len_left = int'(b[6:0]);
            ph       = dtw_pkg::PH_LENX;
          end
        end else begin
          len_acc = {25'd0, b[6:0]};
          close_header();
        end
      end
      dtw_pkg::PH_LENX: begin
        len_acc = {len_acc[23:0], b};
        len_left--;
        if (len_left == 0) close_header();
      end
      dtw_pkg::PH_SKIP: begin
        body_left--;
        if (body_left == 0) ph = dtw_pkg::PH_TAG;
      end
      dtw_pkg::PH_INT: begin
        int_acc = {int_acc[23:0], b};
        body_left--;
        if (body_left == 0) begin
          add_result(dtw_pkg::KIND_INT, '0, '0, int_acc, 2'd0);
          ph = dtw_pkg::PH_TAG;
        end
      end
      dtw_pkg::PH_OID: begin
        take_oid_byte(b);
        if (ph == dtw_pkg::PH_OID) begin
          body_left--;
          if (body_left == 0) ph = dtw_pkg::PH_TAG;
        end
      end
      default: ph = dtw_pkg::PH_HALT;
    endcase
    if (fin) begin
      if (!err_hit) begin
        if (ph != dtw_pkg::PH_TAG || seq_left > 0)
          add_result(dtw_pkg::KIND_ERROR, '0, '0, '0, dtw_pkg::ERR_TRUNC);
        else add_result(dtw_pkg::KIND_END, '0, '0, '0, 2'd0);
      end
      clear_walk();
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    for (int i = 0; i < int'(step_n); i++) exp_q.push_back(step_res[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                res_idx, name, got, want));
  endtask

  task automatic check_result();
    walk_res_t w;
    if (exp_q.size() == 0) begin
      report_mismatch($sformatf("result %0d: kind %0d arrived with nothing expected",
                                res_idx, out_kind));
    end else begin
      w = exp_q.pop_front();
      check_field("kind", 32'(out_kind), 32'(w.kind));
      check_field("tag_class", 32'(out_tag_class), 32'(w.cls));
      check_field("constructed", 32'(out_constructed), 32'(w.cons));
      check_field("tag_number", 32'(out_tag_number), 32'(w.tnum));
      check_field("value_length", out_value_length, w.vlen);
      check_field("arc_value", 32'(out_arc_value), 32'(w.arc));
      check_field("int_value", out_int_value, w.ival);
      check_field("error_code", 32'(out_error_code), 32'(w.err));
      check_field("last", 32'(out_last), 32'(w.last));
    end
    res_idx++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walk();
      exp_q.delete();
      res_idx    = 0;
      fail_count = 0;
      pending   <= 0;
    end else begin
      // predict first so a byte's expectations exist before its results
      if (in_valid && in_ready) predict_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) check_result();
      pending <= exp_q.size();
    end
  end

endmodule

[test/tb_der_tlv_stream_walker.sv]
// Testbench top for the DER TLV stream walker: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on dtw_pkg,
// der_tlv_stream_walker and der_tlv_walk_checker.
module tb_der_tlv_stream_walker;

  // Slowest honest run: ~200 bytes, three results each, random receiver stalls
  // and one long hold; the limit is several times that.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned DRAIN_CYCLES    = 20;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [1:0]  out_tag_class;
  logic        out_constructed;
  logic [4:0]  out_tag_number;
  logic [31:0] out_value_length;
  logic [27:0] out_arc_value;
  logic [31:0] out_int_value;
  logic [1:0]  out_error_code;
  logic        out_last;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned clean_bytes = 0;

  // Bytes of the buffer under construction; the last one carries the end flag.
  logic [7:0]  frame_q[$];

  der_tlv_stream_walker u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tag_class    (out_tag_class),
    .out_constructed  (out_constructed),
    .out_tag_number   (out_tag_number),
    .out_value_length (out_value_length),
    .out_arc_value    (out_arc_value),
    .out_int_value    (out_int_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  der_tlv_walk_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tag_class    (out_tag_class),
    .out_constructed  (out_constructed),
    .out_tag_number   (out_tag_number),
    .out_value_length (out_value_length),
    .out_arc_value    (out_arc_value),
    .out_int_value    (out_int_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a transaction never completes.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold on request so the
  // result queue fills and the walker has to drop in_ready.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one byte and hold it until the transaction completes. Returns at
  // the accepting edge, so the next call drives valid exactly once there.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send the whole buffer, flag its final byte, then drop it.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Insert tag and length in front of the contents that start at pos. Mostly
  // short form; sometimes long form, now and then padded with leading zero bytes up to four.
  function automatic void insert_header(int unsigned pos, logic [7:0] tag, int unsigned len);
    logic [7:0]  hdr[6];
    int unsigned hn;
    int unsigned nb;
    logic [31:0] sh;
    hdr[0] = tag;
    hn     = 1;
    if (len < 128 && $urandom_range(7) != 0) begin
      hdr[1] = 8'(len);
      hn     = 2;
    end else begin
      nb = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
      if ($urandom_range(3) == 0) nb = $urandom_range(dtw_pkg::MAX_LEN_BYTES, nb);
      hdr[1] = 8'h80 | 8'(nb);
      hn     = 2;
      for (int i = int'(nb) - 1; i >= 0; i--) begin
        sh      = len >> (8 * i);
        hdr[hn] = sh[7:0];
        hn++;
      end
    end
    for (int i = int'(hn) - 1; i >= 0; i--) frame_q.insert(pos, hdr[i]);
  endfunction

  // Random arc, mostly one or two base-128 digits, now and then the all-ones
  // value of its digit count.
  function automatic logic [27:0] rand_arc();
    int unsigned d;
    d = ($urandom_range(3) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
    if ($urandom_range(15) == 0) return 28'hFFFFFFF >> (28 - 7 * d);
    return 28'($urandom) >> (28 - 7 * d);
  endfunction

  function automatic void put_arc(logic [27:0] v);
    int          nd;
    logic [27:0] sh;
    nd = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
    for (int i = nd - 1; i > 0; i--) begin
      sh = v >> (7 * i);
      frame_q.push_back({1'b1, sh[6:0]});
    end
    frame_q.push_back({1'b0, v[6:0]});
  endfunction

  // One primitive TLV: INTEGER (sometimes too long to decode), OID (sometimes
  // empty, past the arc cap, or cut inside an arc) or some skipped type.
  function automatic void put_leaf();
    int unsigned pos;
    int unsigned sel;
    logic [4:0]  tn;
    logic [2:0]  cb;
    pos = frame_q.size();
    sel = $urandom_range(9);
    cb  = ($urandom_range(3) == 0) ? 3'($urandom) : 3'd0;
    if (sel < 4) begin
      tn = dtw_pkg::TAG_INTEGER;
      repeat ($urandom_range(6)) frame_q.push_back(8'($urandom));
    end else if (sel < 7) begin
      tn = dtw_pkg::TAG_OID;
      if ($urandom_range(9) != 0) begin
        put_arc(rand_arc());
        repeat ($urandom_range(9)) put_arc(rand_arc());
        if ($urandom_range(7) == 0) frame_q.push_back(8'h80 | 8'($urandom));
      end
    end else begin
      do tn = 5'($urandom);
      while (tn == dtw_pkg::TAG_INTEGER || tn == dtw_pkg::TAG_OID ||
             tn == dtw_pkg::TAG_SEQUENCE || tn == dtw_pkg::TAG_SET);
      repeat ($urandom_range(5)) frame_q.push_back(8'($urandom));
    end
    insert_header(pos, {cb, tn}, frame_q.size() - pos);
  endfunction

  // SEQUENCE or SET holding up to three children, nesting down to depth 0.
  function automatic void put_constructed(int unsigned depth);
    int unsigned pos;
    logic [1:0]  cls;
    logic [4:0]  tn;
    pos = frame_q.size();
    cls = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd0;
    tn  = ($urandom_range(1) == 0) ? dtw_pkg::TAG_SET : dtw_pkg::TAG_SEQUENCE;
    repeat ($urandom_range(3)) begin
      if (depth > 0 && $urandom_range(2) == 0) put_constructed(depth - 1);
      else put_leaf();
    end
    insert_header(pos, {cls, 1'b1, tn}, frame_q.size() - pos);
  endfunction

  function automatic void build_clean_frame();
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(1) == 0) put_constructed(1);
      else put_leaf();
    end
  endfunction

  // Broken buffers: cut short, one byte corrupted, pure noise, a bad length
  // form, or an arc running past four digits.
  function automatic void build_broken_frame();
    int unsigned cut;
    case ($urandom_range(4))
      0: begin
        build_clean_frame();
        if (frame_q.size() > 1) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          repeat (cut) frame_q.delete(frame_q.size() - 1);
        end
      end
      1: begin
        build_clean_frame();
        frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom);
      end
      2: repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
      3: begin
        frame_q.push_back(8'($urandom));
        if ($urandom_range(1) == 0) frame_q.push_back(8'h80);
        else frame_q.push_back(8'h80 | 8'($urandom_range(127, dtw_pkg::MAX_LEN_BYTES + 1)));
        repeat ($urandom_range(3)) frame_q.push_back(8'($urandom));
      end
      default: begin
        frame_q.push_back({3'd0, dtw_pkg::TAG_OID});
        frame_q.push_back(8'd6);
        repeat (5) frame_q.push_back({1'b1, 7'($urandom)});
        frame_q.push_back(8'($urandom_range(127)));
      end
    endcase
  endfunction

  // One idling setting: mostly clean buffers with random content, the rest
  // broken ones. Only clean bytes count toward the phase's share.
  task automatic run_random(input int unsigned s_pct, input int unsigned r_pct);
    int unsigned target;
    send_idle_pct  = s_pct;
    recv_idle_pct <= r_pct;
    target = clean_bytes + ITEMS_PER_PHASE;
    while (clean_bytes < target) begin
      if ($urandom_range(3) != 0) begin
        build_clean_frame();
        clean_bytes += frame_q.size();
      end else begin
        build_broken_frame();
      end
      send_frame();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 21;
    recv_idle_pct <= 56;

    // Widest header: all tag bits set, four-byte length of all ones, buffer
    // ends right after it -> header then truncation.
    frame_q = '{8'hFF, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // Empty INTEGER, then a full four-byte INTEGER of all ones, clean end.
    frame_q = '{8'h02, 8'h00, 8'h02, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // OID inside a SEQUENCE: first byte splits into two arcs, then a
    // two-digit arc.
    frame_q = '{8'h30, 8'h05, 8'h06, 8'h03, 8'h2B, 8'h81, 8'h00};
    send_frame();
    // Indefinite length: error, and the final byte adds nothing.
    frame_q = '{8'h30, 8'h80};
    send_frame();
    // Arc with a fourth continuation byte.
    frame_q = '{8'h06, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();

    run_random(21, 56);
    run_random(56, 21);
    // No idling on either side; hold the receiver off for a long stretch
    // while bytes keep coming so the walker fills and stalls its input.
    hold_req <= 1'b1;
    run_random(0, 0);
    in_valid <= 1'b0;

    // Let the last transaction's expectations land, drain, then wait out the
    // pipeline so stray results still show up.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
